FILE: hdl/tss_pkg.sv
`timescale 1ns / 1ps

package tss_pkg;

  localparam int SLOTS_DEF = 16;

  // event codes
  typedef enum logic [3:0] {
    CMD_INIT    = 4'd0,
    CMD_TICK    = 4'd1,
    CMD_FAULT   = 4'd2,
    CMD_TRACE   = 4'd3,
    CMD_EXIT    = 4'd4,
    CMD_SYSCALL = 4'd5,
    CMD_NEW     = 4'd6,
    CMD_SLEEP   = 4'd7,
    CMD_GETCHAR = 4'd8,
    CMD_KEY     = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_READY  = 2'd1,
    ST_ASLEEP = 2'd2,
    ST_WAIT   = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_EMPTY = 2'd1,
    MODE_WAIT  = 2'd2,
    MODE_SCHED = 2'd3
  } scan_mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_READY = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       act;
    logic       init_step;
    logic       scan_setup;
    scan_mode_t scan_mode;
    logic       scan_run;
    logic       finish;
    logic       publish;
  } tss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] command;
    logic       key_zero;
    logic       scan_done;
    logic       out_free;
  } tss_stat_t;

endpackage

FILE: hdl/tss_if.sv
`timescale 1ns / 1ps

interface tss_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic [31:0]        now_seconds;
  logic signed [15:0] sleep_seconds;
  logic [7:0]         key_char;

  modport source (output valid, command, now_seconds, sleep_seconds, key_char, input ready);
  modport sink (input valid, command, now_seconds, sleep_seconds, key_char, output ready);
endinterface

interface tss_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] running_slot;
  logic [3:0] child_slot;
  logic [1:0] status;
  logic       char_valid;
  logic [3:0] char_slot;
  logic [7:0] char_value;

  modport source (output valid, running_slot, child_slot, status, char_valid, char_slot,
                  char_value, input ready);
  modport sink (input valid, running_slot, child_slot, status, char_valid, char_slot,
                char_value, output ready);
endinterface

FILE: hdl/tss_ram.sv
`timescale 1ns / 1ps

module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tss_datapath.sv
`timescale 1ns / 1ps

module tss_datapath import tss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tss_cmd_t           ctl,
  output tss_stat_t          stat,
  input  logic [3:0]         command,
  input  logic [31:0]        now_seconds,
  input  logic signed [15:0] sleep_seconds,
  input  logic [7:0]         key_char,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [3:0]         running_slot,
  output logic [3:0]         child_slot,
  output logic [1:0]         status,
  output logic               char_valid,
  output logic [3:0]         char_slot,
  output logic [7:0]         char_value
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (IW > 4) ? IW : 4;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);

  // latched request
  logic [3:0]  cmd_q;
  logic [31:0] now_q;
  logic [15:0] slp_q;
  logic [7:0]  key_q;

  // architectural state
  logic [IW-1:0]    cur;
  logic [IW-1:0]    cur_inc;
  logic [7:0]       char_buf;
  logic [SLOTS-1:0] vld;

  // per-request working registers
  scan_mode_t    mode;
  logic          found;
  logic [IW-1:0] found_slot;
  logic          full;
  logic [IW-1:0] child;
  logic          cvalid;
  logic [IW-1:0] cslot;
  logic [7:0]    cval;
  status_t       status_q;

  // scan engine
  logic [IW-1:0] ptr;
  logic [IW-1:0] ptr_inc;
  logic [CW-1:0] cnt;
  logic          rd_vld;
  logic [IW-1:0] rd_addr;
  logic          issue;
  logic          proc;
  logic          hit_low;
  logic          expired;
  logic          eff_ready;
  slot_st_t      rd_state;
  logic [1:0]    st_rdata;
  logic [31:0]   wk_rdata;
  logic [31:0]   wake_diff;

  // ram write port
  logic          st_we;
  logic [IW-1:0] st_waddr;
  slot_st_t      st_wdata;
  logic          wk_we;
  logic [31:0]   wk_wdata;

  // slot numbers widened before taking the low nibble
  logic [XW-1:0] cur_x;
  logic [XW-1:0] child_x;
  logic [XW-1:0] cslot_x;

  assign cur_inc = (cur == LAST_SLOT) ? '0 : cur + 1'b1;
  assign ptr_inc = (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;

  assign issue = ctl.scan_run && (cnt != SCAN_END) && !(found && mode != MODE_SCHED);
  assign proc  = ctl.scan_run && rd_vld;

  assign rd_state  = vld[rd_addr] ? slot_st_t'(st_rdata) : ST_EMPTY;
  assign wake_diff = wk_rdata - now_q;
  assign expired   = (rd_state == ST_ASLEEP) && ((wake_diff == '0) || wake_diff[31]);
  assign eff_ready = (rd_state == ST_READY) || expired;
  assign hit_low   = proc && !found &&
                     (((mode == MODE_EMPTY) && (rd_state == ST_EMPTY)) ||
                      ((mode == MODE_WAIT) && (rd_state == ST_WAIT)));

  assign wk_we    = ctl.act && (cmd_q == CMD_SLEEP);
  assign wk_wdata = now_q + {{16{slp_q[15]}}, slp_q};

  always_comb begin
    st_we    = 1'b0;
    st_waddr = cur;
    st_wdata = ST_READY;
    if (ctl.act) begin
      unique case (cmd_q) inside
        CMD_INIT: begin
          st_we = 1'b1;
        end
        CMD_TICK, CMD_SYSCALL, CMD_TRACE, CMD_NEW, CMD_KEY: begin
          st_we = 1'b0;
        end
        CMD_SLEEP: begin
          st_we    = 1'b1;
          st_wdata = ST_ASLEEP;
        end
        CMD_GETCHAR: begin
          st_we    = (char_buf == '0);
          st_wdata = ST_WAIT;
        end
        default: begin
          st_we    = 1'b1;
          st_wdata = ST_EMPTY;
        end
      endcase
    end else if (ctl.init_step) begin
      st_we    = 1'b1;
      st_waddr = cur_inc;
    end else if (hit_low || (proc && mode == MODE_SCHED && expired)) begin
      st_we    = 1'b1;
      st_waddr = rd_addr;
    end
  end

  tss_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (issue),
    .raddr (ptr),
    .rdata (st_rdata)
  );

  tss_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_wake_ram (
    .clk   (clk),
    .we    (wk_we),
    .waddr (cur),
    .wdata (wk_wdata),
    .re    (issue),
    .raddr (ptr),
    .rdata (wk_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      char_buf  <= '0;
      vld       <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (st_we) begin
        vld[st_waddr] <= 1'b1;
      end
      if (ctl.init_step) begin
        cur <= cur_inc;
      end
      if (ctl.act && cmd_q == CMD_GETCHAR && char_buf != '0) begin
        char_buf <= '0;
      end
      if (ctl.finish && mode == MODE_SCHED && found) begin
        cur <= found_slot;
      end
      if (ctl.finish && mode == MODE_WAIT && !found) begin
        char_buf <= key_q;
      end
      if (ctl.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      now_q  <= now_seconds;
      slp_q  <= sleep_seconds;
      key_q  <= key_char;
      child  <= '0;
      cvalid <= 1'b0;
      cslot  <= '0;
      cval   <= '0;
      full   <= 1'b0;
      found  <= 1'b0;
      mode   <= MODE_NONE;
    end
    if (ctl.act && cmd_q == CMD_GETCHAR && char_buf != '0) begin
      cvalid <= 1'b1;
      cslot  <= cur;
      cval   <= char_buf;
    end
    if (ctl.scan_setup) begin
      mode  <= ctl.scan_mode;
      found <= 1'b0;
      cnt   <= '0;
      ptr   <= (ctl.scan_mode == MODE_SCHED) ? cur_inc : '0;
      if (ctl.scan_mode == MODE_SCHED && mode == MODE_EMPTY) begin
        full <= !found;
      end
    end
    if (issue) begin
      ptr     <= ptr_inc;
      cnt     <= cnt + 1'b1;
      rd_addr <= ptr;
    end
    if (hit_low) begin
      found <= 1'b1;
      if (mode == MODE_EMPTY) begin
        child <= rd_addr;
      end else begin
        cvalid <= 1'b1;
        cslot  <= rd_addr;
        cval   <= key_q;
      end
    end
    if (proc && mode == MODE_SCHED && !found && eff_ready) begin
      found      <= 1'b1;
      found_slot <= rd_addr;
    end
    if (ctl.finish) begin
      if (mode == MODE_SCHED && !found) begin
        status_q <= STATUS_NO_READY;
      end else if (full) begin
        status_q <= STATUS_FULL;
      end else begin
        status_q <= STATUS_OK;
      end
    end
  end

  assign cur_x   = XW'(cur);
  assign child_x = XW'(child);
  assign cslot_x = XW'(cslot);

  // result register, free for the next request once loaded
  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      running_slot <= cur_x[3:0];
      child_slot   <= child_x[3:0];
      status       <= status_q;
      char_valid   <= cvalid;
      char_slot    <= cslot_x[3:0];
      char_value   <= cval;
    end
  end

  assign stat.command   = cmd_q;
  assign stat.key_zero  = (key_q == '0);
  assign stat.scan_done = ((cnt == SCAN_END) && !rd_vld) || (found && mode != MODE_SCHED);
  assign stat.out_free  = !rsp_valid || rsp_ready;

endmodule

FILE: hdl/tss_ctrl.sv
`timescale 1ns / 1ps

module tss_ctrl import tss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  tss_stat_t stat,
  output tss_cmd_t  ctl
);

  typedef enum logic [8:0] {
    S_IDLE        = 9'b000000001,
    S_ACT         = 9'b000000010,
    S_INIT2       = 9'b000000100,
    S_SETUP_LOW   = 9'b000001000,
    S_SCAN_LOW    = 9'b000010000,
    S_SETUP_SCHED = 9'b000100000,
    S_SCAN_SCHED  = 9'b001000000,
    S_FINISH      = 9'b010000000,
    S_DONE        = 9'b100000000
  } fsm_t;

  fsm_t state;
  fsm_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        ctl.act = 1'b1;
        unique case (stat.command) inside
          CMD_INIT:  state_next = S_INIT2;
          CMD_TRACE: state_next = S_FINISH;
          CMD_NEW:   state_next = S_SETUP_LOW;
          CMD_KEY:   state_next = stat.key_zero ? S_FINISH : S_SETUP_LOW;
          default:   state_next = S_SETUP_SCHED;
        endcase
      end
      S_INIT2: begin
        ctl.init_step = 1'b1;
        state_next    = S_FINISH;
      end
      S_SETUP_LOW: begin
        ctl.scan_setup = 1'b1;
        ctl.scan_mode  = (stat.command == CMD_KEY) ? MODE_WAIT : MODE_EMPTY;
        state_next     = S_SCAN_LOW;
      end
      S_SCAN_LOW: begin
        ctl.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = (stat.command == CMD_KEY) ? S_FINISH : S_SETUP_SCHED;
        end
      end
      S_SETUP_SCHED: begin
        ctl.scan_setup = 1'b1;
        ctl.scan_mode  = MODE_SCHED;
        state_next     = S_SCAN_SCHED;
      end
      S_SCAN_SCHED: begin
        ctl.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/thread_slot_scheduler.sv
`timescale 1ns / 1ps

// Round-robin thread scheduler over SLOTS slots (empty, ready, asleep, waiting for a
// character) with per-slot wake times and a one-character keyboard buffer. Each request
// on req carries an event code and gives exactly one response on rsp: the slot that runs
// next, the slot handed to a new thread, a status (ok, table full, no ready slot) and an
// optional character delivery. Slot states and wake times live in two small RAMs with a
// registered read; one scan unit walks them one slot per clock. A scheduling event (tick,
// syscall, fault, exit, sleep, getchar) runs the scheduling scan, a new thread the
// empty-slot scan and then the scheduling scan, a key the waiting-slot scan, and init,
// trace or a null key none. The scan for the lowest empty or waiting slot stops at the
// first hit; the scheduling scan always visits every slot because it also wakes expired
// sleepers. The result sits in an output register, so the next request is taken while
// it waits. Reset clears all slots to empty through per-slot valid bits, no clearing pass.

module thread_slot_scheduler import tss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tss_req_if.sink   req,
  tss_rsp_if.source rsp
);

  tss_cmd_t  ctl;
  tss_stat_t stat;
  logic      req_ready;

  assign req.ready = req_ready;

  // sequencer: one request at a time, walks the scan unit
  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // slot tables, scan unit and response register
  tss_datapath #(.SLOTS(SLOTS)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .command       (req.command),
    .now_seconds   (req.now_seconds),
    .sleep_seconds (req.sleep_seconds),
    .key_char      (req.key_char),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .running_slot  (rsp.running_slot),
    .child_slot    (rsp.child_slot),
    .status        (rsp.status),
    .char_valid    (rsp.char_valid),
    .char_slot     (rsp.char_slot),
    .char_value    (rsp.char_value)
  );

endmodule

FILE: hdl/tss_checker.sv
`timescale 1ns / 1ps

module tss_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [3:0] running_slot,
  input logic [1:0] status,
  input logic       char_valid,
  input logic [3:0] char_slot,
  input logic [7:0] char_value
);

  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(running_slot) && $stable(status) &&
                                $stable(char_valid) && $stable(char_value))
    else $error("stalled response changed");

  // no delivery means zero slot and zero character
  a_no_char: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !char_valid |-> char_slot == 4'd0 && char_value == 8'd0)
    else $error("character fields set without delivery");

  // a delivered character is never the empty marker, and status stays in range
  a_char_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!char_valid || char_value != 8'd0) && status != 2'd3)
    else $error("bad delivered character or status code");

endmodule

bind thread_slot_scheduler tss_checker u_tss_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .running_slot (rsp.running_slot),
  .status       (rsp.status),
  .char_valid   (rsp.char_valid),
  .char_slot    (rsp.char_slot),
  .char_value   (rsp.char_value)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for thread_slot_scheduler.
// Every request is sent through the req channel. When the block accepts it, an
// in-bench scheduler model predicts the one response that the request must
// produce, and that prediction is queued. Each response on rsp is checked field
// by field against the oldest queued prediction. A directed pass covers the
// corner events first. Random bursts follow: a broad command mix, filling the
// slot table, sleepers across the 32-bit time wrap, keyboard traffic, plain
// noise, and the broad mix again under long receiver hold-offs.

module tb_top;
  import tss_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  // receiver hold-off that fills the output register and stalls req
  localparam int LONG_HOLD = 300;
  // drain allowance after the last response: one new-thread walk and then some
  localparam int DRAIN_CYCLES = 2 * NSLOT + 20;

  // one expected response
  typedef struct packed {
    logic [3:0] running_slot;
    logic [3:0] child_slot;
    logic [1:0] status;
    logic       char_valid;
    logic [3:0] char_slot;
    logic [7:0] char_value;
  } dispatch_t;

  // command mixes for the random bursts
  typedef enum int {
    BURST_MIXED,
    BURST_FILL,
    BURST_SLEEPY,
    BURST_CHARS,
    BURST_NOISE
  } burst_kind_t;

  logic clk;
  logic rst;

  tss_req_if req_ch ();
  tss_rsp_if rsp_ch ();

  thread_slot_scheduler #(.SLOTS(NSLOT)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler model state, mirrors the block after every accepted request
  slot_st_t    slot_tbl [NSLOT];
  logic [31:0] wake_at [NSLOT];
  int          run_slot;
  logic [7:0]  kbd_buf;

  dispatch_t   pending_dispatch [$];
  int unsigned mismatches;

  // stimulus time base, advanced by the random bursts
  logic [31:0] clock_now;
  // random idling on both channels while set
  logic        idle_on;
  // each increment asks the receiver for one long hold-off
  int unsigned hold_asks;

  // gap length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // apply one event to the model and return the response it must produce
  function automatic dispatch_t predict_dispatch(input logic [3:0] cmd,
                                                 input logic [31:0] now,
                                                 input logic signed [15:0] slp,
                                                 input logic [7:0] key);
    dispatch_t   d;
    logic        walk;
    logic        full;
    logic        hit;
    logic        found;
    logic [31:0] diff;
    int          s;
    d = '0;
    walk = 1'b1;
    full = 1'b0;
    hit = 1'b0;
    found = 1'b0;
    case (cmd)
      CMD_INIT: begin
        // running slot becomes the idle thread, the next one starts running
        slot_tbl[run_slot] = ST_READY;
        run_slot = (run_slot + 1) % NSLOT;
        slot_tbl[run_slot] = ST_READY;
        walk = 1'b0;
      end
      CMD_TICK, CMD_SYSCALL: ;
      CMD_TRACE: walk = 1'b0;
      CMD_NEW: begin
        // lowest empty slot takes the child
        full = 1'b1;
        for (int i = 0; i < NSLOT; i++) begin
          if (full && slot_tbl[i] == ST_EMPTY) begin
            slot_tbl[i] = ST_READY;
            d.child_slot = 4'(i);
            full = 1'b0;
          end
        end
      end
      CMD_SLEEP: begin
        slot_tbl[run_slot] = ST_ASLEEP;
        wake_at[run_slot] = now + {{16{slp[15]}}, slp};
      end
      CMD_GETCHAR: begin
        if (kbd_buf == '0) begin
          slot_tbl[run_slot] = ST_WAIT;
        end else begin
          d.char_valid = 1'b1;
          d.char_slot = 4'(run_slot);
          d.char_value = kbd_buf;
          kbd_buf = '0;
        end
      end
      CMD_KEY: begin
        walk = 1'b0;
        if (key != '0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!hit && slot_tbl[i] == ST_WAIT) begin
              slot_tbl[i] = ST_READY;
              d.char_valid = 1'b1;
              d.char_slot = 4'(i);
              d.char_value = key;
              hit = 1'b1;
            end
          end
          // no waiter: the key replaces whatever sits in the buffer
          if (!hit) kbd_buf = key;
        end
      end
      // fault, exit and the unused codes all kill the running thread
      default: slot_tbl[run_slot] = ST_EMPTY;
    endcase

    if (walk) begin
      // wake sleepers whose signed time difference is zero or negative
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_tbl[i] == ST_ASLEEP) begin
          diff = wake_at[i] - now;
          if (diff == '0 || diff[31]) slot_tbl[i] = ST_READY;
        end
      end
      // round-robin from the slot after the running one, running slot last
      for (int k = 1; k <= NSLOT; k++) begin
        s = (run_slot + k) % NSLOT;
        if (!found && slot_tbl[s] == ST_READY) begin
          run_slot = s;
          found = 1'b1;
        end
      end
    end

    // no ready slot wins over table full
    if (walk && !found) d.status = STATUS_NO_READY;
    else if (full) d.status = STATUS_FULL;
    d.running_slot = 4'(run_slot);
    return d;
  endfunction

  // drive one request from the falling edge and hold it until accepted
  task automatic send_request(input logic [3:0] cmd, input logic [31:0] now,
                              input logic signed [15:0] slp, input logic [7:0] key);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= cmd;
    req_ch.now_seconds   <= now;
    req_ch.sleep_seconds <= slp;
    req_ch.key_char      <= key;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: the model moves on in the same order as the block
    pending_dispatch.push_back(predict_dispatch(cmd, now, slp, key));
  endtask

  // weights are indexed by command code; the last entry covers the unused codes
  function automatic logic [3:0] pick_command(input burst_kind_t kind);
    int w [11];
    int total;
    int r;
    case (kind)
      BURST_FILL:   w = '{2, 10, 3, 3, 3, 6, 45, 12, 12, 4, 0};
      BURST_SLEEPY: w = '{3, 20, 4, 4, 4, 10, 16, 30, 4, 4, 1};
      BURST_CHARS:  w = '{3, 12, 4, 4, 4, 8, 12, 8, 22, 22, 1};
      default:      w = '{3, 15, 6, 6, 6, 10, 18, 14, 10, 10, 2};
    endcase
    total = 0;
    foreach (w[i]) total += w[i];
    r = $urandom_range(total - 1);
    for (int i = 0; i < 11; i++) begin
      if (r < w[i]) begin
        if (i == 10) return 4'($urandom_range(15, int'(CMD_KEY) + 1));
        return 4'(i);
      end
      r -= w[i];
    end
    return CMD_TICK;
  endfunction

  // random requests of one mix; time mostly creeps forward, now and then jumps
  task automatic random_burst(input burst_kind_t kind, input int count);
    logic [3:0]         cmd;
    logic signed [15:0] slp;
    logic [7:0]         key;
    int                 r;
    for (int n = 0; n < count; n++) begin
      if (kind == BURST_NOISE) begin
        send_request(4'($urandom_range(15)), $urandom, 16'($urandom), 8'($urandom));
      end else begin
        cmd = pick_command(kind);
        if ($urandom_range(49) == 0) clock_now = $urandom;
        else clock_now = clock_now + $urandom_range(3);
        r = $urandom_range(9);
        // short sleeps keep threads cycling, a few wild ones hit both extremes
        if (r < 8) slp = 16'($urandom_range(12));
        else if (r < 9) slp = -16'sd1 - 16'($urandom_range(4));
        else slp = 16'($urandom);
        key = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
        send_request(cmd, clock_now, slp, key);
      end
    end
  endtask

  // corner events, one after another from reset
  task automatic test_directed_events();
    idle_on = 1'b1;
    send_request(CMD_TRACE, 32'h0, 16'sh0, 8'h00);         // all empty
    send_request(CMD_TICK, 32'h1, 16'sh0, 8'h00);          // nothing to run
    send_request(CMD_INIT, 32'h2, 16'sh0, 8'h00);          // idle slot 0, run slot 1
    send_request(CMD_NEW, 32'h3, 16'sh0, 8'h00);           // child into slot 2
    // longest sleep, wake time wraps past zero
    send_request(CMD_SLEEP, 32'hFFFF_FFF0, 16'sh7FFF, 8'h00);
    send_request(CMD_TICK, 32'h0000_7FEE, 16'sh0, 8'h00);  // one second early
    send_request(CMD_TICK, 32'h0000_7FEF, 16'sh0, 8'h00);  // exactly on time
    // most negative sleep lands in the past and wakes at once
    send_request(CMD_SLEEP, 32'h8000_0000, 16'sh8000, 8'h00);
    send_request(CMD_GETCHAR, 32'h8000_0001, 16'sh0, 8'h00); // buffer empty, waits
    send_request(CMD_KEY, 32'h8000_0002, 16'sh0, 8'h00);     // null key ignored
    send_request(CMD_KEY, 32'h8000_0003, 16'sh0, 8'hFF);     // goes to the waiter
    send_request(CMD_KEY, 32'h8000_0004, 16'sh0, 8'h80);     // buffered
    send_request(CMD_KEY, 32'h8000_0005, 16'sh0, 8'h41);     // replaces buffer
    send_request(CMD_GETCHAR, 32'h8000_0006, 16'sh0, 8'h00); // served from buffer
    send_request(CMD_SYSCALL, 32'hFFFF_FFFF, 16'sh0, 8'h00);
    send_request(CMD_FAULT, 32'h0, 16'sh0, 8'h00);
    send_request(CMD_EXIT, 32'h0, 16'sh0, 8'h00);
    send_request(4'hF, 32'h0, 16'sh0, 8'h00);              // unused code acts as fault
    send_request(4'hA, 32'h0, 16'sh0, 8'h00);
    send_request(CMD_INIT, 32'h0, 16'sh0, 8'h00);
    send_request(CMD_GETCHAR, 32'h0, 16'sh0, 8'h00);
    send_request(CMD_GETCHAR, 32'h0, 16'sh0, 8'h00);       // nobody left ready
    send_request(CMD_KEY, 32'h0, 16'sh0, 8'h01);
  endtask

  task automatic test_mixed_traffic();
    idle_on = 1'b1;
    clock_now = $urandom_range(1000);
    random_burst(BURST_MIXED, 600);
  endtask

  // new-thread heavy: table full, and full with every thread blocked
  task automatic test_table_full();
    idle_on = 1'b1;
    random_burst(BURST_FILL, 200);
  endtask

  // sleepers across the 32-bit wrap, back to back with no idling
  task automatic test_sleep_wrap();
    idle_on = 1'b0;
    clock_now = 32'hFFFF_FF80;
    random_burst(BURST_SLEEPY, 250);
  endtask

  task automatic test_keyboard();
    idle_on = 1'b1;
    random_burst(BURST_CHARS, 250);
  endtask

  // receiver parks for a long stretch while requests keep coming
  task automatic test_backpressure();
    idle_on = 1'b1;
    hold_asks++;
    random_burst(BURST_MIXED, 50);
    idle_on = 1'b0;
    hold_asks++;
    random_burst(BURST_MIXED, 50);
  endtask

  task automatic test_noise();
    idle_on = 1'b1;
    random_burst(BURST_NOISE, 250);
  endtask

  // response side: random stalls, plus the long hold-offs asked for above
  initial begin : rsp_sink
    int unsigned stall;
    int unsigned hold_seen;
    rsp_ch.ready = 1'b0;
    stall = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        stall = LONG_HOLD;
      end
      if (stall == 0 && idle_on && $urandom_range(99) < 30) stall = pick_gap();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // every accepted response against the oldest prediction
  always @(posedge clk) begin : rsp_check
    dispatch_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_dispatch.size() == 0) begin
        mismatches++;
        $display("%0t ns: response with no request outstanding, expected none, actual slot %0d",
                 $time, rsp_ch.running_slot);
      end else begin
        want = pending_dispatch.pop_front();
        compare_field("running_slot", want.running_slot, rsp_ch.running_slot);
        compare_field("child_slot", want.child_slot, rsp_ch.child_slot);
        compare_field("status", want.status, rsp_ch.status);
        compare_field("char_valid", want.char_valid, rsp_ch.char_valid);
        compare_field("char_slot", want.char_slot, rsp_ch.char_slot);
        compare_field("char_value", want.char_value, rsp_ch.char_value);
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : main
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_TICK;
    req_ch.now_seconds = '0;
    req_ch.sleep_seconds = '0;
    req_ch.key_char = '0;
    mismatches = 0;
    idle_on = 1'b1;
    hold_asks = 0;
    clock_now = '0;
    // model reset: all slots empty, buffer empty, slot 0 running
    foreach (slot_tbl[i]) begin
      slot_tbl[i] = ST_EMPTY;
      wake_at[i] = '0;
    end
    run_slot = 0;
    kbd_buf = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_mixed_traffic();
    test_table_full();
    test_sleep_wrap();
    test_keyboard();
    test_backpressure();
    test_noise();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    idle_on = 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk);
    // catch any stray response after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tss_pkg.sv
hdl/tss_if.sv
hdl/tss_ram.sv
hdl/tss_datapath.sv
hdl/tss_ctrl.sv
hdl/thread_slot_scheduler.sv
hdl/tss_checker.sv
tb/tb_top.sv
